### rtl/core/prc_pkg.sv
// Shared constants, CORDIC arctan table and register codes for the point rotation block.
package prc_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ANGLE_BITS   = 17;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;

    // CORDIC datapath widths: vector in Q1.30 with headroom, angle in 2^-23 degree
    localparam int CORDIC_BITS = 33;
    localparam int ZACC_BITS   = 32;
    localparam int TRIG_BITS   = 30;          // cos/sin in Q2.28

    localparam int INV_GAIN_Q30 = 652032874;
    localparam int ONE_Q30      = 1073741824;

    localparam int ATAN_COUNT = 30;
    localparam int ATAN_IDX_W = $clog2(ATAN_COUNT);

    localparam logic [ZACC_BITS-1:0] ATAN_TABLE [ATAN_COUNT] = '{
        32'd377487360, 32'd222843801, 32'd117744544, 32'd59768969, 32'd30000467,
        32'd15014858,  32'd7509261,   32'd3754860,   32'd1877459,  32'd938733,
        32'd469367,    32'd234683,    32'd117342,    32'd58671,    32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,     32'd917,
        32'd458,       32'd229,       32'd115,       32'd57,       32'd29,
        32'd14,        32'd7,         32'd4,         32'd2,        32'd1
    };

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ANGLE   = 2'd0;
    localparam t_cfg_idx CFG_PIVOT_X = 2'd1;
    localparam t_cfg_idx CFG_PIVOT_Y = 2'd2;

endpackage

### rtl/core/prc_in_if.sv
// Vertex input channel: valid/ready with x, y and last-vertex marker.
interface prc_in_if #(
    parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         in_last;

    modport source (output valid, in_x, in_y, in_last, input ready);
    modport sink   (input valid, in_x, in_y, in_last, output ready);
endinterface

### rtl/core/prc_out_if.sv
// Vertex output channel: valid/ready with rotated x, y and last-vertex marker.
interface prc_out_if #(
    parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_last;

    modport source (output valid, out_x, out_y, out_last, input ready);
    modport sink   (input valid, out_x, out_y, out_last, output ready);
endinterface

### rtl/core/prc_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
interface prc_cfg_if #(
    parameter int DATA_BITS = prc_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    prc_pkg::t_cfg_idx     idx;
    logic [DATA_BITS-1:0]  data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

### rtl/core/point_rotation_about_center.sv
// Rotation of a Q16.16 vertex stream about a configured pivot point.
//
// Channels: i_cfg writes rotation_angle (index 0, 1/128 degree), pivot_x (1)
// and pivot_y (2); other indexes are ignored. i_vtx takes vertices, o_vtx
// returns one rotated, saturated vertex per input with last copied through.
// A transfer happens on any rising edge with valid and ready high.
//
// Throughput: one vertex per cycle while o_vtx.ready is high and no angle update
// is running. The vertex path is a chain of register stages (offset, partial
// products, partial sums, rounding, pivot add with saturation).
// An angle write starts the iterative CORDIC unit that computes cos/sin once
// per angle; i_vtx.ready and i_cfg.ready stay low while it runs (load, the
// CORDIC steps, fold and round).
// Reset: angle and pivot are 0 and cos/sin hold the exact identity, so the
// block is ready for vertices in the first cycle after reset.
// Stall: when o_vtx.ready is low the stages fill up behind the output
// register; bubbles are squeezed out and nothing is dropped or repeated.
module point_rotation_about_center #(
    parameter int COORD_BITS   = prc_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prc_cfg_if.sink   i_cfg,
    prc_in_if.sink    i_vtx,
    prc_out_if.source o_vtx
);

    localparam int C      = COORD_BITS;
    localparam int D      = C + 1;                 // offset width
    localparam int HW     = D - 16;                // high part of offset
    localparam int T      = prc_pkg::TRIG_BITS;
    localparam int PH     = HW + T;
    localparam int PL     = 17 + T;
    localparam int SW     = HW + 48;               // exact sum width
    localparam int RW     = SW - 28;               // rounded rotation
    localparam int FW     = RW + 1;                // after pivot add
    localparam int CW     = prc_pkg::CORDIC_BITS;
    localparam int ZW     = prc_pkg::ZACC_BITS;
    localparam int AB     = prc_pkg::ANGLE_BITS;
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic signed [SW-1:0] RND_HALF = {{(SW-28){1'b0}}, 1'b1, {27{1'b0}}};
    localparam logic signed [FW-1:0] SAT_HI   = {{(FW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [FW-1:0] SAT_LO   = {{(FW-C+1){1'b1}}, {(C-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic signed [AB-1:0] r_angle;
    logic signed [C-1:0]  r_px;
    logic signed [C-1:0]  r_py;
    logic [1:0]           r_state;
    logic                 busy;
    logic                 cfg_xfer;

    assign busy        = (r_state != ST_IDLE);
    assign i_cfg.ready = !busy;
    assign cfg_xfer    = i_cfg.valid && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_px    <= '0;
            r_py    <= '0;
        end else if (cfg_xfer) begin
            unique case (i_cfg.idx)
                prc_pkg::CFG_ANGLE:   r_angle <= i_cfg.data[AB-1:0];
                prc_pkg::CFG_PIVOT_X: r_px    <= i_cfg.data[C-1:0];
                prc_pkg::CFG_PIVOT_Y: r_py    <= i_cfg.data[C-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- angle reduction into quadrant and residual ----------------
    logic signed [AB+1:0] a_w1, a_w2, a_red;
    logic [1:0]           quad;
    logic [13:0]          resid;

    always_comb begin
        a_w1  = (AB+2)'(r_angle);
        if (a_w1 < 0) a_w1 = a_w1 + (AB+2)'(prc_pkg::FULL_TURN);
        a_w2  = a_w1;
        if (a_w2 < 0) a_w2 = a_w2 + (AB+2)'(prc_pkg::FULL_TURN);
        a_red = a_w2;
        if (a_red >= (AB+2)'(prc_pkg::FULL_TURN)) a_red = a_red - (AB+2)'(prc_pkg::FULL_TURN);
        priority if (a_red >= (AB+2)'(3 * prc_pkg::QUARTER_TURN)) begin
            quad  = 2'd3;
            resid = 14'(a_red - (AB+2)'(3 * prc_pkg::QUARTER_TURN));
        end else if (a_red >= (AB+2)'(2 * prc_pkg::QUARTER_TURN)) begin
            quad  = 2'd2;
            resid = 14'(a_red - (AB+2)'(2 * prc_pkg::QUARTER_TURN));
        end else if (a_red >= (AB+2)'(prc_pkg::QUARTER_TURN)) begin
            quad  = 2'd1;
            resid = 14'(a_red - (AB+2)'(prc_pkg::QUARTER_TURN));
        end else begin
            quad  = 2'd0;
            resid = 14'(a_red);
        end
    end

    // ---------------- iterative CORDIC, one step per cycle ----------------
    logic signed [CW-1:0] r_cx, r_cy, n_cx, n_cy;
    logic signed [ZW-1:0] r_cz, n_cz;
    logic [STEP_W-1:0]    r_step;
    logic [1:0]           r_quad;
    logic                 r_rzero;
    logic signed [T-1:0]  r_cos, r_sin;
    logic signed [CW-1:0] xs, ys, cf, sf, c_rnd, s_rnd;
    logic signed [ZW-1:0] atan_val;

    always_comb begin
        xs       = r_cx >>> r_step;
        ys       = r_cy >>> r_step;
        atan_val = $signed(prc_pkg::ATAN_TABLE[prc_pkg::ATAN_IDX_W'(r_step)]);
        if (!r_cz[ZW-1]) begin
            n_cx = r_cx - ys;
            n_cy = r_cy + xs;
            n_cz = r_cz - atan_val;
        end else begin
            n_cx = r_cx + ys;
            n_cy = r_cy - xs;
            n_cz = r_cz + atan_val;
        end
    end

    // residual zero means an exact multiple of a quarter turn
    always_comb begin
        logic signed [CW-1:0] c0, s0;
        c0 = r_rzero ? CW'(prc_pkg::ONE_Q30) : r_cx;
        s0 = r_rzero ? '0 : r_cy;
        unique case (r_quad)
            2'd1:    begin cf = -s0; sf = c0;  end
            2'd2:    begin cf = -c0; sf = -s0; end
            2'd3:    begin cf = s0;  sf = -c0; end
            default: begin cf = c0;  sf = s0;  end
        endcase
        c_rnd = cf + CW'(2);
        s_rnd = sf + CW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cos   <= T'(prc_pkg::ONE_Q30 >> 2);
            r_sin   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (cfg_xfer && i_cfg.idx == prc_pkg::CFG_ANGLE) r_state <= ST_INIT;
                end
                ST_INIT: begin
                    r_cx    <= CW'(prc_pkg::INV_GAIN_Q30);
                    r_cy    <= '0;
                    r_cz    <= ZW'({resid, 16'd0});
                    r_quad  <= quad;
                    r_rzero <= (resid == '0);
                    r_step  <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_cx   <= n_cx;
                    r_cy   <= n_cy;
                    r_cz   <= n_cz;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) r_state <= ST_FIN;
                end
                default: begin
                    // Q1.30 -> Q2.28, round half up
                    r_cos   <= c_rnd[T+1:2];
                    r_sin   <= s_rnd[T+1:2];
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------- vertex pipeline ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || o_vtx.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_vtx.ready = en1 && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_vtx.valid && !busy;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: offset from pivot
    logic signed [D-1:0] r1_dx, r1_dy;
    logic                r1_last;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_dx   <= D'(i_vtx.in_x) - D'(r_px);
            r1_dy   <= D'(i_vtx.in_y) - D'(r_py);
            r1_last <= i_vtx.in_last;
        end
    end

    // stage 2: partial products, offsets split into signed high and 16-bit low
    logic signed [HW-1:0] dxh, dyh;
    logic signed [16:0]   dxl, dyl;
    logic signed [PH-1:0] r2_hxc, r2_hys, r2_hyc, r2_hxs;
    logic signed [PL-1:0] r2_lxc, r2_lys, r2_lyc, r2_lxs;
    logic                 r2_last;

    assign dxh = r1_dx[D-1:16];
    assign dyh = r1_dy[D-1:16];
    assign dxl = $signed({1'b0, r1_dx[15:0]});
    assign dyl = $signed({1'b0, r1_dy[15:0]});

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_hxc  <= PH'(dxh) * PH'(r_cos);
            r2_hys  <= PH'(dyh) * PH'(r_sin);
            r2_hyc  <= PH'(dyh) * PH'(r_cos);
            r2_hxs  <= PH'(dxh) * PH'(r_sin);
            r2_lxc  <= PL'(dxl) * PL'(r_cos);
            r2_lys  <= PL'(dyl) * PL'(r_sin);
            r2_lyc  <= PL'(dyl) * PL'(r_cos);
            r2_lxs  <= PL'(dxl) * PL'(r_sin);
            r2_last <= r1_last;
        end
    end

    // stage 3: x' uses dx*c - dy*s, y' uses dy*c + dx*s
    logic signed [PH:0] r3_hx, r3_hy;
    logic signed [PL:0] r3_lx, r3_ly;
    logic               r3_last;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_hx   <= (PH+1)'(r2_hxc) - (PH+1)'(r2_hys);
            r3_hy   <= (PH+1)'(r2_hyc) + (PH+1)'(r2_hxs);
            r3_lx   <= (PL+1)'(r2_lxc) - (PL+1)'(r2_lys);
            r3_ly   <= (PL+1)'(r2_lyc) + (PL+1)'(r2_lxs);
            r3_last <= r2_last;
        end
    end

    // stage 4: recombine, round half up from Q.44 to Q.16
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [RW-1:0] r4_rx, r4_ry;
    logic                 r4_last;

    assign sum_x = (SW'(r3_hx) <<< 16) + SW'(r3_lx) + RND_HALF;
    assign sum_y = (SW'(r3_hy) <<< 16) + SW'(r3_ly) + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_rx   <= sum_x[SW-1:28];
            r4_ry   <= sum_y[SW-1:28];
            r4_last <= r3_last;
        end
    end

    // stage 5: back to pivot, saturate to the coordinate range
    logic signed [FW-1:0] fin_x, fin_y;
    logic signed [C-1:0]  sat_x, sat_y;
    logic signed [C-1:0]  r5_x, r5_y;
    logic                 r5_last;

    assign fin_x = FW'(r4_rx) + FW'(r_px);
    assign fin_y = FW'(r4_ry) + FW'(r_py);

    always_comb begin
        priority if (fin_x > SAT_HI) sat_x = SAT_HI[C-1:0];
        else if (fin_x < SAT_LO)     sat_x = SAT_LO[C-1:0];
        else                         sat_x = fin_x[C-1:0];
        priority if (fin_y > SAT_HI) sat_y = SAT_HI[C-1:0];
        else if (fin_y < SAT_LO)     sat_y = SAT_LO[C-1:0];
        else                         sat_y = fin_y[C-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_x    <= sat_x;
            r5_y    <= sat_y;
            r5_last <= r4_last;
        end
    end

    assign o_vtx.valid    = r_v5;
    assign o_vtx.out_x    = r5_x;
    assign o_vtx.out_y    = r5_y;
    assign o_vtx.out_last = r5_last;

endmodule
